// ===== rtl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk_s, rstn_s, expr, msg) \
  `ASSERT_IMPL(label, clk_s, rstn_s, !(expr), msg)

`endif

// ===== rtl/hft_pkg.sv =====
// shared types, constants and command codes of the huffman tree decoder
// no dependencies; used by hft_ctrl, hft_datapath and the top level
`default_nettype none

package hft_pkg;

  // node table geometry
  localparam int NODE_COUNT   = 512;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int CNT_W        = $clog2(NODE_COUNT + 1);

  // code word geometry
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int MAX_CODE_LEN = 16;
  localparam int SYM_W        = 8;
  localparam int BYTE_BITS    = 8;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // controller to datapath commands
  typedef logic [3:0] op_t;
  localparam op_t CMD_NONE       = 4'd0;
  localparam op_t CMD_CLEAR_STEP = 4'd1;
  localparam op_t CMD_TAKE_LOAD  = 4'd2;
  localparam op_t CMD_TAKE_DATA  = 4'd3;
  localparam op_t CMD_LOAD_STEP  = 4'd4;
  localparam op_t CMD_MARK       = 4'd5;
  localparam op_t CMD_WALK_STEP  = 4'd6;
  localparam op_t CMD_WALK_END   = 4'd7;
  localparam op_t CMD_FLUSH      = 4'd8;

  typedef struct packed {
    op_t op;
  } hft_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic load_full;
  } hft_sts_t;

  // one entry of the node table, child index 0 means absent
  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [SYM_W-1:0]  sym;
  } node_t;

endpackage

`default_nettype wire

// ===== rtl/hft_ctrl.sv =====
// sequencer of the huffman tree decoder: clear pass, code load and byte walk
// depends on hft_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hft_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [1:0]                in_kind,
  input  wire logic [hft_pkg::LEN_W-1:0] in_code_length,
  input  wire hft_pkg::hft_sts_t         sts,
  output logic                           busy,
  output hft_pkg::hft_cmd_t              cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [hft_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic                      len_ok;

  assign len_ok = (in_code_length != '0) &&
                  (int'(in_code_length) <= hft_pkg::MAX_CODE_LEN);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = hft_pkg::CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_kind)
            hft_pkg::KIND_LOAD: begin
              if (len_ok) begin
                cmd.op    = hft_pkg::CMD_TAKE_LOAD;
                cnt_nxt   = in_code_length - 1'b1;
                state_nxt = ST_LOAD;
              end
            end
            hft_pkg::KIND_DATA: begin
              cmd.op    = hft_pkg::CMD_TAKE_DATA;
              cnt_nxt   = hft_pkg::LEN_W'(hft_pkg::BYTE_BITS - 1);
              state_nxt = ST_WALK;
            end
            hft_pkg::KIND_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.op = hft_pkg::CMD_CLEAR_STEP;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cmd.op = hft_pkg::CMD_LOAD_STEP;
        if (sts.load_full) begin
          state_nxt = ST_IDLE;
        end else if (cnt_r == '0) begin
          state_nxt = ST_MARK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MARK: begin
        cmd.op    = hft_pkg::CMD_MARK;
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        cmd.op = hft_pkg::CMD_WALK_STEP;
        if (cnt_r == '0) begin
          state_nxt = ST_END;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_END: begin
        cmd.op    = hft_pkg::CMD_WALK_END;
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.op    = hft_pkg::CMD_FLUSH;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a byte walk always ends in its flush, after its walk steps and the walk end
  `ASSERT_IMPL(a_walk_len, clk, rst_n, (state_r == ST_IDLE && start && in_kind == hft_pkg::KIND_DATA) |-> ##10 (cmd.op == hft_pkg::CMD_FLUSH), "byte walk did not end in flush")

endmodule

`default_nettype wire

// ===== rtl/hft_datapath.sv =====
// node table memory, walk registers and result staging of the huffman tree decoder
// depends on hft_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hft_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire hft_pkg::hft_cmd_t          cmd,
  input  wire logic [hft_pkg::SYM_W-1:0]  in_symbol_in,
  input  wire logic [hft_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hft_pkg::LEN_W-1:0]  in_code_length,
  input  wire logic [7:0]                 in_data_byte,
  output hft_pkg::hft_sts_t               sts,
  output logic                            out_valid,
  output logic [hft_pkg::SYM_W-1:0]       out_decoded_symbol,
  output logic                            out_bad_code,
  output logic                            out_last_of_byte
);

  localparam int NW = hft_pkg::NODE_W;
  localparam int CW = hft_pkg::CNT_W;

  // where the node under the walk comes from
  localparam logic [1:0] SRC_MEM  = 2'd0;
  localparam logic [1:0] SRC_ROOT = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  hft_pkg::node_t mem [hft_pkg::NODE_COUNT];
  hft_pkg::node_t rd_r;
  hft_pkg::node_t wdata, base, root_node, step_node;
  logic [NW-1:0]  raddr, waddr, child;
  logic           we, bitv, full, result_now, take_result;
  logic [hft_pkg::LEN_W-1:0] amt;

  logic [NW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]                 nfree_r, nfree_nxt;
  logic [NW-1:0]                 walk_r, walk_nxt;
  logic [NW-1:0]                 root_l_r, root_l_nxt, root_r_r, root_r_nxt;
  logic [NW-1:0]                 cur_r, cur_nxt;
  logic [1:0]                    src_r, src_nxt;
  logic [hft_pkg::CODE_W-1:0]    sh_r, sh_nxt;
  logic [hft_pkg::SYM_W-1:0]     sym_r, sym_nxt;
  logic                          pend_r, pend_nxt, nzero_r, nzero_nxt;
  logic                          hold_v_r, hold_v_nxt, hold_bad_r, hold_bad_nxt;
  logic [hft_pkg::SYM_W-1:0]     hold_sym_r, hold_sym_nxt;
  logic                          out_v_r, out_v_nxt, out_bad_r, out_bad_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [hft_pkg::SYM_W-1:0]     out_sym_r, out_sym_nxt;

  assign root_node = '{left: root_l_r, right: root_r_r, leaf: 1'b0, sym: '0};

  always_comb begin
    case (src_r)
      SRC_ROOT: base = root_node;
      SRC_ZERO: base = '0;
      default:  base = rd_r;
    endcase
  end

  // outcome of the previous walk step: missing child or leaf reached
  assign result_now = pend_r && (nzero_r || rd_r.leaf);
  assign step_node  = result_now ? root_node : base;
  assign bitv       = sh_r[hft_pkg::CODE_W-1];
  assign child      = bitv ? step_node.right : step_node.left;
  assign full       = (nfree_r == CW'(hft_pkg::NODE_COUNT));
  assign amt        = hft_pkg::LEN_W'(hft_pkg::CODE_W) - in_code_length;

  assign sts.clr_done  = (clr_addr_r == NW'(hft_pkg::NODE_COUNT - 1));
  assign sts.load_full = (child == '0) && full;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    nfree_nxt    = nfree_r;
    walk_nxt     = walk_r;
    root_l_nxt   = root_l_r;
    root_r_nxt   = root_r_r;
    cur_nxt      = cur_r;
    src_nxt      = src_r;
    sh_nxt       = sh_r;
    sym_nxt      = sym_r;
    pend_nxt     = pend_r;
    nzero_nxt    = nzero_r;
    hold_v_nxt   = hold_v_r;
    hold_sym_nxt = hold_sym_r;
    hold_bad_nxt = hold_bad_r;
    out_v_nxt    = 1'b0;
    out_sym_nxt  = out_sym_r;
    out_bad_nxt  = out_bad_r;
    out_last_nxt = out_last_r;
    we           = 1'b0;
    waddr        = cur_r;
    wdata        = step_node;
    raddr        = child;
    take_result  = 1'b0;
    case (cmd.op)
      hft_pkg::CMD_CLEAR_STEP: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = sts.clr_done ? '0 : clr_addr_r + 1'b1;
        nfree_nxt    = CW'(1);
        walk_nxt     = '0;
        root_l_nxt   = '0;
        root_r_nxt   = '0;
        pend_nxt     = 1'b0;
        hold_v_nxt   = 1'b0;
      end
      hft_pkg::CMD_TAKE_LOAD: begin
        sh_nxt   = in_code_bits << amt;
        sym_nxt  = in_symbol_in;
        cur_nxt  = '0;
        src_nxt  = SRC_ROOT;
        pend_nxt = 1'b0;
      end
      hft_pkg::CMD_TAKE_DATA: begin
        raddr    = walk_r;
        sh_nxt   = {in_data_byte, (hft_pkg::CODE_W - 8)'(0)};
        cur_nxt  = walk_r;
        src_nxt  = SRC_MEM;
        pend_nxt = 1'b0;
      end
      hft_pkg::CMD_LOAD_STEP: begin
        sh_nxt = sh_r << 1;
        if (child == '0) begin
          if (!full) begin
            we = 1'b1;
            if (bitv) begin
              wdata.right = nfree_r[NW-1:0];
            end else begin
              wdata.left = nfree_r[NW-1:0];
            end
            if (cur_r == '0) begin
              root_l_nxt = wdata.left;
              root_r_nxt = wdata.right;
            end
            cur_nxt   = nfree_r[NW-1:0];
            nfree_nxt = nfree_r + 1'b1;
            src_nxt   = SRC_ZERO;
          end
        end else begin
          cur_nxt = child;
          src_nxt = SRC_MEM;
        end
      end
      hft_pkg::CMD_MARK: begin
        we         = 1'b1;
        wdata      = base;
        wdata.leaf = 1'b1;
        wdata.sym  = sym_r;
      end
      hft_pkg::CMD_WALK_STEP: begin
        sh_nxt      = sh_r << 1;
        cur_nxt     = child;
        src_nxt     = SRC_MEM;
        pend_nxt    = 1'b1;
        nzero_nxt   = (child == '0);
        take_result = result_now;
      end
      hft_pkg::CMD_WALK_END: begin
        pend_nxt    = 1'b0;
        walk_nxt    = result_now ? '0 : cur_r;
        take_result = result_now;
      end
      hft_pkg::CMD_FLUSH: begin
        if (hold_v_r) begin
          out_v_nxt    = 1'b1;
          out_sym_nxt  = hold_sym_r;
          out_bad_nxt  = hold_bad_r;
          out_last_nxt = 1'b1;
        end
        hold_v_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    // one result is held back so the last of a byte can be flagged
    if (take_result) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_sym_nxt  = hold_sym_r;
        out_bad_nxt  = hold_bad_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_sym_nxt = nzero_r ? '0 : rd_r.sym;
      hold_bad_nxt = nzero_r;
    end
  end

  // node table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      nfree_r    <= CW'(1);
      walk_r     <= '0;
      pend_r     <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      nfree_r    <= nfree_nxt;
      walk_r     <= walk_nxt;
      pend_r     <= pend_nxt;
      hold_v_r   <= hold_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_l_r   <= root_l_nxt;
    root_r_r   <= root_r_nxt;
    cur_r      <= cur_nxt;
    src_r      <= src_nxt;
    sh_r       <= sh_nxt;
    sym_r      <= sym_nxt;
    nzero_r    <= nzero_nxt;
    hold_sym_r <= hold_sym_nxt;
    hold_bad_r <= hold_bad_nxt;
    out_sym_r  <= out_sym_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_bad_code       = out_bad_r;
  assign out_last_of_byte   = out_last_r;

  `ASSERT_NEVER(a_nfree_range, clk, rst_n, nfree_r == '0 || nfree_r > CW'(hft_pkg::NODE_COUNT), "free node pointer out of range")
  `ASSERT_NEVER(a_bad_sym, clk, rst_n, out_v_r && out_bad_r && out_sym_r != '0, "bad code word carries a symbol")
  `ASSERT_IMPL(a_flush_empty, clk, rst_n, (cmd.op == hft_pkg::CMD_FLUSH) |=> !hold_v_r, "held word survived flush")
  `ASSERT_IMPL(a_last_at_flush, clk, rst_n, (out_v_r && out_last_r) |-> $past(cmd.op == hft_pkg::CMD_FLUSH), "last flag outside flush")

endmodule

`default_nettype wire

// ===== rtl/huffman_tree_decoder_top.sv =====
// top level of the binary tree huffman decoder
// depends on hft_pkg, hft_ctrl and hft_datapath
`default_nettype none

// binary tree huffman decoder. an item is taken when start is high and busy is
// low. kind load walks the node table from the root one code bit per cycle,
// allocating missing children, then marks the leaf; it ends early, with no
// mark, if the table runs full. kind data walks the eight bits of the byte,
// one node table read per bit. kind clear, and reset itself, run a clearing
// pass over the 512 node entries, one entry per cycle, with busy high while
// it runs. results come one word per cycle on out_valid and cannot be held
// off by the receiver; a byte gives zero to eight words, the last of them
// flagged by out_last_of_byte, and a step to a missing child gives a word with
// out_bad_code set and symbol zero

module huffman_tree_decoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item side
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [hft_pkg::SYM_W-1:0]  in_symbol_in,
  input  wire logic [hft_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hft_pkg::LEN_W-1:0]  in_code_length,
  input  wire logic [7:0]                 in_data_byte,
  // result side
  output logic                            out_valid,
  output logic [hft_pkg::SYM_W-1:0]       out_decoded_symbol,
  output logic                            out_bad_code,
  output logic                            out_last_of_byte
);

  // command from the sequencer, status back from the datapath
  hft_pkg::hft_cmd_t cmd;
  hft_pkg::hft_sts_t sts;

  // sequencer: clear pass, load steps, walk steps and flush of the last word
  hft_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_kind        (in_kind),
    .in_code_length (in_code_length),
    .sts            (sts),
    .busy           (busy),
    .cmd            (cmd)
  );

  // node table memory, walk position, free pointer and output word staging
  hft_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_symbol_in       (in_symbol_in),
    .in_code_bits       (in_code_bits),
    .in_code_length     (in_code_length),
    .in_data_byte       (in_data_byte),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_decoded_symbol (out_decoded_symbol),
    .out_bad_code       (out_bad_code),
    .out_last_of_byte   (out_last_of_byte)
  );

endmodule

`default_nettype wire
